/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the edge filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/svef_pkg.sv */
// Types, constants and helpers for the vertical Sobel edge filter.
`timescale 1ns / 1ps
`default_nettype none

package svef_pkg;

    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned MAX_HEIGHT_DEF = 1024;

    localparam int unsigned PIX_W = 8;
    localparam int unsigned CFG_W = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;
    localparam int unsigned MIN_SIZE = 3;

    localparam int unsigned FIFO_DEPTH = 3;
    localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_result;

    typedef struct packed {
        logic [FIFO_CW-1:0] count;
        logic               full;
    } t_fifo_stat;

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned hi);
        int unsigned val;
        val = int'(v);
        if (val < MIN_SIZE) return MIN_SIZE;
        if (val > hi) return hi;
        return val;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/svef_out_fifo.sv */
// Small register FIFO that holds finished results for the output stream.
`timescale 1ns / 1ps
`default_nettype none

module svef_out_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire svef_pkg::t_result   i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output svef_pkg::t_result        o_data,
    output svef_pkg::t_fifo_stat     o_stat
);

    svef_pkg::t_result r_mem [svef_pkg::FIFO_DEPTH];
    logic [svef_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [svef_pkg::FIFO_CW-1:0] r_count;
    logic pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count == svef_pkg::FIFO_CW'(svef_pkg::FIFO_DEPTH));

    function automatic logic [svef_pkg::FIFO_AW-1:0] ptr_inc(
            input logic [svef_pkg::FIFO_AW-1:0] p);
        if (p == svef_pkg::FIFO_AW'(svef_pkg::FIFO_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sobel_vertical_edge_filter.sv */
// Top level of the streaming 3x3 vertical Sobel edge filter.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+-------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: pixel[7:0]; tuser: pad
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: edge_value[7:0];
//          |     |                               | tlast: frame_last
//  cfg     | in  | i_cfg_we                      | i_cfg_idx, i_cfg_data
//
// One item per clock while s_axis_tready is high; it drops only when the FIFO
// plus the item in flight could run out of room. An item reads the line
// memory at the accept edge and is finished in the next cycle, when its
// column is written back and its result enters a three-entry output FIFO;
// a back-to-back access to the same column is forwarded. Reset is synchronous
// and clears counters, window and FIFO; the line memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sobel_vertical_edge_filter #(
    parameter int unsigned MAX_WIDTH  = svef_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = svef_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] pixel
    input  wire logic                           s_axis_tuser,  // [0] pad
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,  // [7:0] edge_value
    output logic                                m_axis_tlast,
    input  wire logic                           i_cfg_we,
    input  wire logic [svef_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [svef_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int unsigned PW = svef_pkg::PIX_W;
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
    localparam int unsigned CW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int unsigned MW = WW + HW;
    localparam int unsigned W_RST =
        svef_pkg::clamp_size(svef_pkg::FRAME_WIDTH_RST, MAX_WIDTH);
    localparam int unsigned H_RST =
        svef_pkg::clamp_size(svef_pkg::FRAME_HEIGHT_RST, MAX_HEIGHT);

    // ---------------- configuration ----------------
    logic [WW-1:0] r_w, cfg_w;
    logic [HW-1:0] r_h, cfg_h;
    logic [CW-1:0] r_total_m1;
    logic [MW-1:0] cfg_prod;

    always_comb begin
        cfg_w = r_w;
        cfg_h = r_h;
        if (i_cfg_idx == svef_pkg::REG_FRAME_WIDTH) begin
            cfg_w = WW'(svef_pkg::clamp_size(i_cfg_data, MAX_WIDTH));
        end
        if (i_cfg_idx == svef_pkg::REG_FRAME_HEIGHT) begin
            cfg_h = HW'(svef_pkg::clamp_size(i_cfg_data, MAX_HEIGHT));
        end
        cfg_prod = MW'(cfg_w) * MW'(cfg_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w        <= WW'(W_RST);
            r_h        <= HW'(H_RST);
            r_total_m1 <= CW'(W_RST * H_RST - 1);
        end else if (i_cfg_we) begin
            r_w        <= cfg_w;
            r_h        <= cfg_h;
            r_total_m1 <= CW'(cfg_prod - MW'(1));
        end
    end

    // ---------------- accept stage: position tracking ----------------
    logic [AW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_count, n_count;
    logic          accept, emit0, border0, last0;
    logic [WW-1:0] col_ext, col_inc;

    // output side signals used by the ready decision
    svef_pkg::t_fifo_stat w_fstat;
    logic                 r_s1_valid, r_s1_emit;

    localparam int unsigned FIFO_SUM_W = svef_pkg::FIFO_CW + 1;
    assign s_axis_tready = ((FIFO_SUM_W)'(w_fstat.count) + (FIFO_SUM_W)'(r_s1_emit))
                           < (FIFO_SUM_W)'(svef_pkg::FIFO_DEPTH);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        col_ext = WW'(r_col);
        col_inc = col_ext + 1'b1;
        emit0   = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_col != '0));
        // the centre is one column left of the incoming item and one row up
        border0 = (r_col == '0) || (r_col == AW'(1)) || (col_ext >= r_w)
                  || (r_row == RW'(1)) || (r_row >= RW'(r_h));
        last0   = emit0 && (r_count >= r_total_m1);

        n_col   = r_col;
        n_row   = r_row;
        n_count = r_count;
        if (last0) begin
            n_col   = '0;
            n_row   = '0;
            n_count = '0;
        end else begin
            if (emit0) begin
                n_count = r_count + 1'b1;
            end
            if (col_inc >= r_w) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = AW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_count <= n_count;
        end
    end

    // ---------------- line memory: {line above, line middle} per column ------
    logic [2*PW-1:0] r_line_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd_word, r_fwd_word, wr_word, s1_word;
    logic [AW-1:0]   r_s1_col;
    logic            r_s1_fwd, r_s1_border, r_s1_last;
    logic [PW-1:0]   r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_word <= r_line_mem[r_col];
        end
        if (r_s1_valid) begin
            r_line_mem[r_s1_col] <= wr_word;
        end
    end

    // payload of the item in flight
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col    <= r_col;
            r_s1_pix    <= s_axis_tuser ? '0 : s_axis_tdata;
            r_s1_border <= border0;
            r_s1_last   <= last0;
            r_fwd_word  <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s1_emit  <= accept && emit0;
            // the write of the item in flight lands at the same edge as this read
            r_s1_fwd   <= accept && r_s1_valid && (r_s1_col == r_col);
        end
    end

    // ---------------- finish stage: window and gradient ----------------
    logic [PW-1:0] r_top0, r_top1, r_bot0, r_bot1;
    logic [PW-1:0] top_new, mid_new;
    logic [PW+1:0] upper, lower;
    logic signed [PW+2:0] diff;
    svef_pkg::t_result res;

    always_comb begin
        s1_word = r_s1_fwd ? r_fwd_word : r_rd_word;
        top_new = s1_word[2*PW-1:PW];
        mid_new = s1_word[PW-1:0];
        wr_word = {mid_new, r_s1_pix};

        upper = (PW+2)'(r_top0) + {1'b0, r_top1, 1'b0} + (PW+2)'(top_new);
        lower = (PW+2)'(r_bot0) + {1'b0, r_bot1, 1'b0} + (PW+2)'(r_s1_pix);
        diff  = $signed({1'b0, lower}) - $signed({1'b0, upper});

        if (r_s1_border || diff[PW+2]) begin
            res.edge_value = '0;
        end else if (diff[PW+1:PW] != 2'b00) begin
            res.edge_value = '1;
        end else begin
            res.edge_value = diff[PW-1:0];
        end
        res.frame_last = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top0 <= '0;
            r_top1 <= '0;
            r_bot0 <= '0;
            r_bot1 <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_top0 <= '0;
                r_top1 <= '0;
                r_bot0 <= '0;
                r_bot1 <= '0;
            end else begin
                r_top0 <= r_top1;
                r_top1 <= top_new;
                r_bot0 <= r_bot1;
                r_bot1 <= r_s1_pix;
            end
        end
    end

    // ---------------- output ----------------
    svef_pkg::t_result w_out;

    svef_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_emit),
        .i_data  (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out),
        .o_stat  (w_fstat)
    );

    assign m_axis_tdata = w_out.edge_value;
    assign m_axis_tlast = w_out.frame_last;

    // ---------------- checks ----------------
    `ASSERT_NEVER(a_fifo_overflow, i_clk, i_rst_n, r_s1_emit && w_fstat.full && !(m_axis_tvalid && m_axis_tready), "result pushed into a full output FIFO")
    `ASSERT_CLK(a_frame_restart, i_clk, i_rst_n, accept && last0 |=> (r_col == '0) && (r_row == '0) && (r_count == '0), "position not cleared after the last item of a frame")
    `ASSERT_CLK(a_fwd_source, i_clk, i_rst_n, r_s1_fwd |-> $past(r_s1_valid) && r_s1_valid, "forward taken without a write in flight")
    `ASSERT_CLK(a_emit_in_flight, i_clk, i_rst_n, r_s1_emit |-> r_s1_valid, "result flagged without an item in flight")

endmodule

`default_nettype wire
